[hw/rtl/gss_pkg.sv]
// shared constants and types of the grover search block
`default_nettype none
package gss_pkg;

   localparam int MaxQubitsDefault = 10;
   localparam int AmpBitsDefault   = 32;
   localparam int SumBits          = 48;
   localparam int ProbBits         = 17;
   localparam int QubitBits        = 4;
   localparam int IterBits         = 8;
   localparam int CsrDataBits      = 8;
   localparam int CsrIndexBits     = 1;
   localparam logic [ProbBits-1:0] ProbOne = 17'd65536;

   typedef enum logic [0:0] {
      CMD_MARK = 1'b0,
      CMD_RUN  = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_QUBITS = 1'b0,
      CSR_ITERS  = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROOT,
      ST_FILL,
      ST_ORACLE,
      ST_ORACLE_WB,
      ST_MEAN,
      ST_DIFF,
      ST_DIFF_WB,
      ST_PROB,
      ST_SQUARE,
      ST_ACCUM,
      ST_DONE
   } state_type;

endpackage : gss_pkg
`default_nettype wire

[hw/rtl/gss_root.sv]
// bit-pair restoring square root of a power of two, one result bit per cycle
`default_nettype none
module gss_root
   import gss_pkg::*;
#(
   parameter int AMP_BITS = AmpBitsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [6:0]          exponent,
   output logic                     done,
   output logic [AMP_BITS-1:0]      root
);

   localparam int RootBits = AMP_BITS;
   localparam int RemBits  = AMP_BITS + 2;

   logic [RootBits-1:0] root_ff, root_in;
   logic [RemBits-1:0]  rem_ff, rem_in;
   logic [6:0]          pos_ff, pos_in;
   logic [6:0]          top_ff, top_in;
   logic                exp_odd_ff, exp_odd_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [RemBits-1:0]  rem_shift;
   logic [RemBits-1:0]  trial;
   logic [1:0]          pair;

   always_comb begin
      pair      = (pos_ff == top_ff) ? (exp_odd_ff ? 2'd2 : 2'd1) : 2'd0;
      rem_shift = {rem_ff[RemBits-3:0], pair};
      trial     = {root_ff[RemBits-3:0], 2'b01};
      root_in    = root_ff;
      rem_in     = rem_ff;
      pos_in     = pos_ff;
      top_in     = top_ff;
      exp_odd_in = exp_odd_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      if (start) begin
         root_in    = '0;
         rem_in     = '0;
         pos_in     = {1'b0, exponent[6:1]};
         top_in     = {1'b0, exponent[6:1]};
         exp_odd_in = exponent[0];
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (rem_shift >= trial) begin
            rem_in  = rem_shift - trial;
            root_in = {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            root_in = {root_ff[RootBits-2:0], 1'b0};
         end
         pos_in = pos_ff - 7'd1;
         if (pos_ff == 7'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      root_ff    <= root_in;
      rem_ff     <= rem_in;
      pos_ff     <= pos_in;
      top_ff     <= top_in;
      exp_odd_ff <= exp_odd_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule : gss_root
`default_nettype wire

[hw/rtl/grover_search_state_vector.sv]
// top level of the grover search engine over a fixed-point state vector
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/ready    | command, state_index, mark_value, random_value
//   rsp     | out       | rsp_valid/ready    | measured_state, found_is_target, marked_prob..
//   csr     | in        | csr_write_enable   | csr_index, csr_write_data
//
// a mark transfer is one mark memory write, the next request is taken right after
// a run goes from its transfer to the result through these steps, in order: root, fill,
// oracle and diffusion once per iteration, probability over every entry, target lookup
// the mark bitmap is cleared by a sweep over all 2^MAX_QUBITS entries after reset,
// during which no request is accepted
// a result waits in its output register while the block stays busy with nothing else
`default_nettype none
module grover_search_state_vector
   import gss_pkg::*;
#(
   parameter int MAX_QUBITS = MaxQubitsDefault,
   parameter int AMP_BITS   = AmpBitsDefault
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_command,
   input  wire logic [9:0]            req_state_index,
   input  wire logic                  req_mark_value,
   input  wire logic [ProbBits-1:0]   req_random_value,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [9:0]                 rsp_measured_state,
   output logic                       rsp_found_is_target,
   output logic [ProbBits-1:0]        rsp_marked_prob,
   output logic [IterBits-1:0]        rsp_iterations_done,
   input  wire logic                  csr_write_enable,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_write_data
);

   localparam int Depth    = 1 << MAX_QUBITS;
   localparam int AddrBits = MAX_QUBITS;
   localparam int CntBits  = MAX_QUBITS + 1;
   localparam int FracBits = AMP_BITS - 2;
   localparam int SqShift  = 2 * FracBits - 16;
   localparam int SqBits   = 2 * AMP_BITS;
   localparam int PsumBits = 48;
   localparam logic signed [AMP_BITS-1:0] AmpMax = {1'b0, {(AMP_BITS-1){1'b1}}};
   localparam logic signed [AMP_BITS-1:0] AmpMin = {1'b1, {(AMP_BITS-1){1'b0}}};
   localparam logic signed [SumBits-1:0]  AsumMax = {1'b0, {(SumBits-1){1'b1}}};
   localparam logic signed [SumBits-1:0]  AsumMin = {1'b1, {(SumBits-1){1'b0}}};
   localparam logic [PsumBits-1:0]        PsumMax = {PsumBits{1'b1}};

   // memories
   logic signed [AMP_BITS-1:0] amp_mem [Depth];
   logic                       mark_mem [Depth];

   // control
   state_type            state_ff, state_in;
   logic [QubitBits-1:0] qubits_ff;
   logic [IterBits-1:0]  iters_ff;
   logic [CntBits-1:0]   clear_ff, clear_in;
   logic [CntBits-1:0]   idx_ff, idx_in;
   logic [IterBits-1:0]  it_ff, it_in;
   logic [QubitBits-1:0] n_ff, n_in;
   logic                 found_ok_ff, found_ok_in;
   logic [AddrBits-1:0]  found_ff, found_in;
   logic [ProbBits-1:0]  rnd_ff, rnd_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [AMP_BITS-1:0] init_ff, init_in;
   logic signed [SumBits-1:0]  asum_ff, asum_in;
   logic signed [SumBits-1:0]  mean_ff, mean_in;
   logic [PsumBits-1:0]  psum_ff, psum_in;
   logic [PsumBits-1:0]  cum_ff, cum_in;
   logic [SqBits-1:0]    sq_ff, sq_in;
   logic [AMP_BITS-1:0]  mag_ff, mag_in;
   logic                 smark_ff, smark_in;
   logic [9:0]           out_state_ff, out_state_in;
   logic                 out_tgt_ff, out_tgt_in;
   logic [ProbBits-1:0]  out_prob_ff, out_prob_in;
   logic [IterBits-1:0]  out_iter_ff, out_iter_in;
   logic                 tgt_pending_ff, tgt_pending_in;
   logic                 tgt_valid_ff;
   logic                 rsp_show;

   // memory ports
   logic                       amp_we, mark_we;
   logic [AddrBits-1:0]        amp_waddr, amp_raddr, mark_waddr, mark_raddr;
   logic signed [AMP_BITS-1:0] amp_wdata, amp_rd_ff;
   logic                       mark_wdata, mark_rd_ff;

   logic                       root_start, root_done;
   logic [AMP_BITS-1:0]        root_val;
   logic [6:0]                 root_exp;

   logic [CntBits-1:0]         dim;
   logic                       last_idx;
   logic [QubitBits-1:0]       n_eff;
   logic signed [AMP_BITS:0]   neg_wide;
   logic signed [SumBits:0]    asum_wide;
   logic signed [SumBits+1:0]  diff_wide;
   logic [PsumBits:0]          psum_wide, cum_wide;
   logic [SqBits-1:0]          prob_shift;
   logic [PsumBits-1:0]        prob_val;
   logic signed [SumBits-1:0]  neg_sum, mean_ceil;

   gss_root #(.AMP_BITS(AMP_BITS)) u_root (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .exponent (root_exp),
      .done     (root_done),
      .root     (root_val)
   );

   always_ff @(posedge clock) begin
      if (amp_we) amp_mem[amp_waddr] <= amp_wdata;
      amp_rd_ff <= amp_mem[amp_raddr];
      if (mark_we) mark_mem[mark_waddr] <= mark_wdata;
      mark_rd_ff <= mark_mem[mark_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qubits_ff <= QubitBits'(4);
         iters_ff  <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_QUBITS: qubits_ff <= csr_write_data[QubitBits-1:0];
            CSR_ITERS:  iters_ff  <= csr_write_data[IterBits-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = qubits_ff;
      if (qubits_ff == '0) n_eff = QubitBits'(1);
      else if ({28'd0, qubits_ff} > MAX_QUBITS) n_eff = QubitBits'(MAX_QUBITS);
   end

   assign dim      = CntBits'(1) << n_ff;
   assign last_idx = (idx_ff == dim - CntBits'(1));
   assign root_exp = 7'(2 * FracBits) - {3'd0, n_ff};

   // response is shown only after the target bit has landed
   assign rsp_show = rsp_valid_ff && !tgt_pending_ff && !tgt_valid_ff;

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      idx_in       = idx_ff;
      it_in        = it_ff;
      n_in         = n_ff;
      found_ok_in  = found_ok_ff;
      found_in     = found_ff;
      rnd_in       = rnd_ff;
      rsp_valid_in = rsp_valid_ff;
      init_in      = init_ff;
      asum_in      = asum_ff;
      mean_in      = mean_ff;
      psum_in      = psum_ff;
      cum_in       = cum_ff;
      sq_in        = sq_ff;
      mag_in       = mag_ff;
      smark_in     = smark_ff;
      out_state_in = out_state_ff;
      out_prob_in  = out_prob_ff;
      out_iter_in  = out_iter_ff;
      amp_we       = 1'b0;
      amp_waddr    = idx_ff[AddrBits-1:0];
      amp_wdata    = init_ff;
      amp_raddr    = idx_ff[AddrBits-1:0];
      mark_we      = 1'b0;
      mark_waddr   = clear_ff[AddrBits-1:0];
      mark_wdata   = 1'b0;
      mark_raddr   = idx_ff[AddrBits-1:0];
      root_start   = 1'b0;
      req_ready    = 1'b0;
      neg_wide     = -{amp_rd_ff[AMP_BITS-1], amp_rd_ff};
      asum_wide    = '0;
      diff_wide    = '0;
      psum_wide    = '0;
      cum_wide     = '0;
      prob_shift   = sq_ff >> SqShift;
      prob_val     = (prob_shift > SqBits'(PsumMax)) ? PsumMax : prob_shift[PsumBits-1:0];
      neg_sum      = -asum_ff;
      mean_ceil    = (neg_sum + ((SumBits'(1) << n_ff) - SumBits'(1))) >>> n_ff;

      if (rsp_show && rsp_ready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // the found entry's mark bit is looked up while the result waits
            mark_raddr = AddrBits'(out_state_ff);
            if (!clear_ff[CntBits-1]) begin
               // post-reset sweep of the mark bitmap
               mark_we  = 1'b1;
               clear_in = clear_ff + CntBits'(1);
            end else if (!rsp_valid_ff) begin
               req_ready = 1'b1;
               if (req_valid) begin
                  if (cmd_type'(req_command) == CMD_MARK) begin
                     mark_we    = 1'b1;
                     mark_waddr = AddrBits'(req_state_index);
                     mark_wdata = req_mark_value;
                  end else begin
                     n_in     = n_eff;
                     rnd_in   = req_random_value;
                     state_in = ST_ROOT;
                  end
               end
            end
         end
         ST_ROOT: begin
            root_start = 1'b1;
            state_in   = ST_MEAN;
            it_in      = '0;
         end
         ST_MEAN: begin
            // waits for the root, then fills
            if (root_done) begin
               init_in  = (root_val > AMP_BITS'(AmpMax)) ? AmpMax : root_val;
               idx_in   = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            amp_we = 1'b1;
            idx_in = idx_ff + CntBits'(1);
            if (last_idx) begin
               idx_in  = '0;
               asum_in = '0;
               state_in = (iters_ff == '0) ? ST_PROB : ST_ORACLE;
            end
         end
         ST_ORACLE: begin
            // read issued at idx, data next cycle
            state_in = ST_ORACLE_WB;
         end
         ST_ORACLE_WB: begin
            amp_we    = 1'b1;
            amp_wdata = amp_rd_ff;
            if (mark_rd_ff)
               amp_wdata = (neg_wide > (AMP_BITS+1)'(AmpMax)) ? AmpMax
                           : neg_wide[AMP_BITS-1:0];
            asum_wide = {asum_ff[SumBits-1], asum_ff} + (SumBits+1)'(amp_wdata);
            if (asum_wide > (SumBits+1)'(AsumMax)) asum_in = AsumMax;
            else if (asum_wide < (SumBits+1)'(AsumMin)) asum_in = AsumMin;
            else asum_in = asum_wide[SumBits-1:0];
            idx_in   = idx_ff + CntBits'(1);
            state_in = ST_ORACLE;
            if (last_idx) begin
               idx_in   = '0;
               state_in = ST_DIFF;
               mean_in  = '0;
            end
         end
         ST_DIFF: begin
            if (idx_ff == '0) begin
               mean_in = asum_ff[SumBits-1] ? -mean_ceil : (asum_ff >>> n_ff);
            end
            state_in = ST_DIFF_WB;
         end
         ST_DIFF_WB: begin
            amp_we    = 1'b1;
            diff_wide = {mean_ff[SumBits-1], mean_ff, 1'b0}
                        - (SumBits+2)'(amp_rd_ff);
            if (diff_wide > (SumBits+2)'(AmpMax)) amp_wdata = AmpMax;
            else if (diff_wide < (SumBits+2)'(AmpMin)) amp_wdata = AmpMin;
            else amp_wdata = diff_wide[AMP_BITS-1:0];
            idx_in   = idx_ff + CntBits'(1);
            state_in = ST_DIFF;
            if (last_idx) begin
               idx_in  = '0;
               asum_in = '0;
               it_in   = it_ff + IterBits'(1);
               state_in = (it_ff + IterBits'(1) == iters_ff) ? ST_PROB : ST_ORACLE;
            end
         end
         ST_PROB: begin
            psum_in     = '0;
            cum_in      = '0;
            found_ok_in = 1'b0;
            found_in    = '0;
            state_in    = ST_SQUARE;
         end
         ST_SQUARE: begin
            // data for idx arrives here
            mag_in   = amp_rd_ff[AMP_BITS-1] ? AMP_BITS'(-amp_rd_ff) : amp_rd_ff;
            smark_in = mark_rd_ff;
            state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            sq_in    = SqBits'(mag_ff) * SqBits'(mag_ff);
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (smark_ff) begin
               psum_wide = {1'b0, psum_ff} + {1'b0, prob_val};
               psum_in   = psum_wide[PsumBits] ? PsumMax : psum_wide[PsumBits-1:0];
            end
            cum_wide = {1'b0, cum_ff} + {1'b0, prob_val};
            cum_in   = cum_wide[PsumBits] ? PsumMax : cum_wide[PsumBits-1:0];
            if (!found_ok_ff && (PsumBits'(rnd_ff) <= cum_in)) begin
               found_ok_in = 1'b1;
               found_in    = idx_ff[AddrBits-1:0];
            end
            idx_in   = idx_ff + CntBits'(1);
            state_in = ST_SQUARE;
            if (last_idx) begin
               idx_in   = idx_ff;
               state_in = ST_IDLE;
               out_state_in = 10'(found_ok_in ? found_in : '0);
               out_prob_in  = (psum_in > PsumBits'(ProbOne)) ? ProbOne
                              : psum_in[ProbBits-1:0];
               out_iter_in  = iters_ff;
               rsp_valid_in = 1'b1;
               idx_in       = '0;
            end
            // fetch the next entry so it lands in the square state
            amp_raddr  = idx_in[AddrBits-1:0];
            mark_raddr = idx_in[AddrBits-1:0];
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // found_is_target needs the mark bit of the found entry: read it once idle
   always_comb begin
      tgt_pending_in = tgt_pending_ff;
      if (state_ff == ST_DONE && state_in == ST_IDLE) tgt_pending_in = 1'b1;
      else if (tgt_pending_ff) tgt_pending_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         clear_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
         tgt_pending_ff <= 1'b0;
         tgt_valid_ff   <= 1'b0;
         idx_ff         <= '0;
         it_ff          <= '0;
         found_ok_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         clear_ff       <= clear_in;
         rsp_valid_ff   <= rsp_valid_in;
         tgt_pending_ff <= tgt_pending_in;
         tgt_valid_ff   <= tgt_pending_ff;
         idx_ff         <= idx_in;
         it_ff          <= it_in;
         found_ok_ff    <= found_ok_in;
      end
      n_ff         <= n_in;
      found_ff     <= found_in;
      rnd_ff       <= rnd_in;
      init_ff      <= init_in;
      asum_ff      <= asum_in;
      mean_ff      <= mean_in;
      psum_ff      <= psum_in;
      cum_ff       <= cum_in;
      sq_ff        <= sq_in;
      mag_ff       <= mag_in;
      smark_ff     <= smark_in;
      out_state_ff <= out_state_in;
      out_prob_ff  <= out_prob_in;
      out_iter_ff  <= out_iter_in;
      out_tgt_ff   <= out_tgt_in;
   end

   // the mark read in idle addresses the found entry; sample it in the cycle after the read
   always_comb begin
      out_tgt_in = out_tgt_ff;
      if (tgt_valid_ff) out_tgt_in = mark_rd_ff;
   end

   assign rsp_valid           = rsp_show;
   assign rsp_measured_state  = out_state_ff;
   assign rsp_found_is_target = out_tgt_ff;
   assign rsp_marked_prob     = out_prob_ff;
   assign rsp_iterations_done = out_iter_ff;

endmodule : grover_search_state_vector
`default_nettype wire

[hw/rtl/grover_search_state_vector_checker.sv]
// port-level checker for the grover search engine, bound to the top level
`default_nettype none
module grover_search_state_vector_checker
   import gss_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_command,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [ProbBits-1:0] rsp_marked_prob,
   input wire logic [IterBits-1:0] rsp_iterations_done
);

   // a response stays up until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // a waiting response keeps its marked probability and iteration count
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_marked_prob) && $stable(rsp_iterations_done))
      else $error("response payload changed before transfer");

   // no request is taken while a response waits
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while response pending");

   // probability never exceeds one
   a_prob_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_marked_prob <= ProbOne)
      else $error("marked probability above one");

   // a mark transfer yields no response next cycle
   a_mark_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_MARK) |=> !rsp_valid)
      else $error("response after a mark command");

endmodule : grover_search_state_vector_checker

bind grover_search_state_vector grover_search_state_vector_checker u_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .req_command         (req_command),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_marked_prob     (rsp_marked_prob),
   .rsp_iterations_done (rsp_iterations_done)
);
`default_nettype wire

[tb/grover_checker.sv]
// checker for the grover search block: predicts each search result and compares it
module grover_checker
   import gss_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   input  wire logic                    req_ready,
   input  wire logic                    req_command,
   input  wire logic [9:0]              req_state_index,
   input  wire logic                    req_mark_value,
   input  wire logic [ProbBits-1:0]     req_random_value,
   input  wire logic                    rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire logic [9:0]              rsp_measured_state,
   input  wire logic                    rsp_found_is_target,
   input  wire logic [ProbBits-1:0]     rsp_marked_prob,
   input  wire logic [IterBits-1:0]     rsp_iterations_done,
   input  wire logic                    csr_write_enable,
   input  wire logic [CsrIndexBits-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]  csr_write_data,
   output int                           error_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [9:0]          state;
      logic                target;
      logic [ProbBits-1:0] prob;
      logic [IterBits-1:0] iters;
   } search_result_type;

   localparam longint AmpHigh = (64'sd1 <<< 31) - 1;
   localparam longint AmpLow  = -(64'sd1 <<< 31);
   localparam longint SumHigh = (64'sd1 <<< 47) - 1;
   localparam longint SumLow  = -(64'sd1 <<< 47);

   search_result_type   search_results[$];
   logic [1023:0]       target_map;
   logic [QubitBits-1:0] qubit_setting;
   logic [IterBits-1:0] iter_setting;
   longint              amplitudes[1024];

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   function automatic longint sat_amp(longint v);
      if (v > AmpHigh) return AmpHigh;
      if (v < AmpLow) return AmpLow;
      return v;
   endfunction

   // q16 probability of one amplitude, truncated
   function automatic longint amp_prob(longint a);
      longint m;
      m = (a < 0) ? -a : a;
      return (m * m) >>> 44;
   endfunction

   function search_result_type predict_search(logic [ProbBits-1:0] sample);
      search_result_type r;
      int n;
      int dim;
      longint root;
      longint trial;
      longint sum;
      longint mean;
      longint psum;
      longint cum;
      bit hit;
      n = qubit_setting;
      if (n < 1) n = 1;
      if (n > 10) n = 10;
      dim = 1 << n;
      // floor of sqrt(2^(60-n)), bit by bit
      root = 0;
      for (int b = 30; b >= 0; b--) begin
         trial = root | (64'sd1 <<< b);
         if (trial * trial <= (64'sd1 <<< (60 - n))) root = trial;
      end
      for (int i = 0; i < dim; i++) amplitudes[i] = root;
      for (int it = 0; it < iter_setting; it++) begin
         sum = 0;
         for (int i = 0; i < dim; i++) begin
            if (target_map[i]) amplitudes[i] = sat_amp(-amplitudes[i]);
            sum += amplitudes[i];
            if (sum > SumHigh) sum = SumHigh;
            if (sum < SumLow) sum = SumLow;
         end
         mean = sum >>> n;
         for (int i = 0; i < dim; i++) amplitudes[i] = sat_amp(2 * mean - amplitudes[i]);
      end
      psum = 0;
      cum = 0;
      hit = 0;
      r.state = '0;
      for (int i = 0; i < dim; i++) begin
         if (target_map[i]) psum += amp_prob(amplitudes[i]);
         cum += amp_prob(amplitudes[i]);
         if (!hit && longint'(sample) <= cum) begin
            r.state = i[9:0];
            hit = 1;
         end
      end
      r.target = target_map[r.state];
      r.prob = (psum > 65536) ? ProbOne : psum[ProbBits-1:0];
      r.iters = iter_setting;
      return r;
   endfunction

   task automatic report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      error_count++;
   endtask

   always @(posedge clock) begin
      search_result_type want;
      if (reset) begin
         target_map <= '0;
         qubit_setting <= 4'd4;
         iter_setting <= '0;
         search_results.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_QUBITS: qubit_setting <= csr_write_data[QubitBits-1:0];
               CSR_ITERS:  iter_setting <= csr_write_data[IterBits-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (cmd_type'(req_command) == CMD_MARK)
               target_map[req_state_index] <= req_mark_value;
            else
               search_results.push_back(predict_search(req_random_value));
         end
         if (rsp_valid && rsp_ready) begin
            if (search_results.size() == 0) begin
               report("result transfer with no search pending");
            end else begin
               want = search_results.pop_front();
               if (rsp_measured_state !== want.state)
                  report($sformatf("measured_state %0d, expected %0d",
                                   rsp_measured_state, want.state));
               if (rsp_found_is_target !== want.target)
                  report($sformatf("found_is_target %0b, expected %0b",
                                   rsp_found_is_target, want.target));
               if (rsp_marked_prob !== want.prob)
                  report($sformatf("marked_prob %0d, expected %0d",
                                   rsp_marked_prob, want.prob));
               if (rsp_iterations_done !== want.iters)
                  report($sformatf("iterations_done %0d, expected %0d",
                                   rsp_iterations_done, want.iters));
            end
         end
      end
      outstanding = search_results.size();
   end

endmodule

[tb/testbench.sv]
// top of the grover search testbench: clock, reset, stimulus and verdict
module testbench;
   import gss_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 300000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_command = 1'b0;
   logic [9:0] req_state_index = '0;
   logic req_mark_value = 1'b0;
   logic [ProbBits-1:0] req_random_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [9:0] rsp_measured_state;
   logic rsp_found_is_target;
   logic [ProbBits-1:0] rsp_marked_prob;
   logic [IterBits-1:0] rsp_iterations_done;
   logic csr_write_enable = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [CsrDataBits-1:0] csr_write_data = '0;

   int error_count;
   int outstanding;
   int idle_cycles = 0;
   bit send_no_gaps = 0;
   bit rsp_no_stalls = 0;
   int rsp_stall = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   grover_search_state_vector u_top (.*);

   grover_checker u_checker (.*);

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_no_stalls) begin
         rsp_ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0)
            rsp_stall <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 60)
                                                     : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic write_settings(int qubits, int iters);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_QUBITS;
      csr_write_data <= qubits[CsrDataBits-1:0];
      @(posedge clock);
      csr_index <= CSR_ITERS;
      csr_write_data <= iters[CsrDataBits-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_request(cmd_type cmd, int index, bit mark, int sample);
      int gap;
      gap = send_no_gaps ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_state_index <= index[9:0];
      req_mark_value <= mark;
      req_random_value <= sample[ProbBits-1:0];
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic mark_state(int index, bit mark);
      send_request(CMD_MARK, index, mark, $urandom_range(0, 131071));
   endtask

   task automatic run_search(int sample);
      send_request(CMD_RUN, $urandom_range(0, 1023), $urandom_range(0, 1), sample);
   endtask

   // wait until the block is idle before touching its settings
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int qubits;
      int iters;
      int span;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: four qubits, no iterations
      mark_state(3, 1);
      run_search(0);
      run_search(65536);
      run_search(131071);
      mark_state(3, 0);
      mark_state(1023, 1);
      run_search(4096);
      drain();
      // zero qubits behave as one
      write_settings(0, 1);
      mark_state(1, 1);
      run_search(1);
      drain();
      // above the maximum runs as ten qubits
      write_settings(15, 2);
      mark_state(700, 1);
      run_search(30000);
      drain();
      write_settings(2, 255);
      mark_state(2, 1);
      mark_state(0, 1);
      run_search(65535);
      drain();
      write_settings(10, 0);
      run_search(65536);
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         send_no_gaps = ($urandom_range(0, 3) == 0);
         rsp_no_stalls = ($urandom_range(0, 3) == 0);
         qubits = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 15) : $urandom_range(0, 6);
         if (qubits >= 7) iters = $urandom_range(0, 3);
         else if (qubits <= 2 && $urandom_range(0, 3) == 0) iters = 255;
         else iters = $urandom_range(0, 20);
         write_settings(qubits, iters);
         span = 1 << ((qubits < 1) ? 1 : (qubits > 10) ? 10 : qubits);
         for (int k = 0; k < 12; k++) begin
            if ($urandom_range(0, 3) == 0)
               run_search(($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                      : $urandom_range(0, 65536));
            else
               mark_state(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023)
                                                      : $urandom_range(0, span - 1),
                          $urandom_range(0, 1));
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
